// ----- rtl/bgc_pkg.sv -----
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared constants, codes and types of the button gesture classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

	// Sizing
	localparam int BUTTON_COUNT  = 3;
	localparam int TIME_BITS     = 32;
	localparam int BTN_IDX_BITS  = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

	// Fixed field widths
	localparam int ID_BITS       = 2;
	localparam int TS_BITS       = 32;
	localparam int KIND_BITS     = 2;
	localparam int MASK_BITS     = 3;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 16;

	// Register reset values
	localparam logic [CFG_DATA_BITS-1:0] COMBO_WINDOW_RST = 16'd200;
	localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_RST   = 16'd750;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_COMBO_WINDOW = 1'b0,
		CFG_LONG_PRESS   = 1'b1
	} cfg_reg_t;

	// Gesture codes
	typedef enum logic [KIND_BITS-1:0] {
		GK_CLICK      = 2'd0,
		GK_LONG       = 2'd1,
		GK_COMBO      = 2'd2,
		GK_LONG_COMBO = 2'd3
	} gesture_kind_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_CLONG,
		S_PUT,
		S_WAIT,
		S_EMIT
	} state_t;

	// Request to the shared time unit
	typedef struct packed {
		logic [TIME_BITS-1:0] a;
		logic [TIME_BITS-1:0] b;
		logic [TIME_BITS-1:0] thr;
		logic                 use_abs;
	} unit_req_t;

	// Response of the shared time unit
	typedef struct packed {
		logic le;
		logic ge;
	} unit_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/bgc_if.sv -----
// ----------------------------------------------------------------------------
// bgc_if
// Channel interfaces: button events in, gestures out, register writes in.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgc_event_if import bgc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ID_BITS-1:0] btn_sel;
	logic               level;
	logic [TS_BITS-1:0] timestamp;

	modport source (output valid, btn_sel, level, timestamp, input ready);
	modport sink   (input valid, btn_sel, level, timestamp, output ready);
endinterface

interface bgc_gesture_if import bgc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KIND_BITS-1:0] gesture_kind;
	logic [MASK_BITS-1:0] button_mask;
	logic                 last_result;

	modport source (output valid, gesture_kind, button_mask, last_result, input ready);
	modport sink   (input valid, gesture_kind, button_mask, last_result, output ready);
endinterface

interface bgc_cfg_if import bgc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bgc_time_unit.sv -----
// ----------------------------------------------------------------------------
// bgc_time_unit
// Shared subtract and compare unit: a - b (optionally its magnitude) against
// a threshold. Used for hold durations, press spreads and press distances.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_time_unit import bgc_pkg::*; (
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	logic [TIME_BITS:0]   diff;
	logic [TIME_BITS-1:0] mag;
	logic                 lt;

	// Subtract with borrow, negate on borrow when the magnitude is wanted
	assign diff = {1'b0, req.a} - {1'b0, req.b};
	assign mag  = (req.use_abs && diff[TIME_BITS]) ? (~diff[TIME_BITS-1:0] + 1'b1)
	                                               : diff[TIME_BITS-1:0];

	// Compare against the threshold
	assign lt     = mag < req.thr;
	assign rsp.le = lt || (mag == req.thr);
	assign rsp.ge = !lt;

endmodule

`default_nettype wire

// ----- rtl/button_gesture_classifier.sv -----
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Turns debounced button edges into click, long press and combo gestures.
// ----------------------------------------------------------------------------
// One event is handled at a time by a sequencer that visits one button per
// cycle and shares a single subtract-and-compare unit. An event with nothing
// pending passes through the scan and decide states only; a lone released
// button is then checked against the others in a further pass and reported
// in another; each gesture beat waits for the output register to be free, and
// the sequencer holds its button meanwhile. An event for a button index of
// BUTTON_COUNT or more is taken and dropped.
// Register writes are taken at any time and must only be made while idle.
`default_nettype none

module button_gesture_classifier import bgc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	bgc_event_if.sink     btn_evt,
	bgc_gesture_if.source gesture,
	bgc_cfg_if.sink       cfg
);

	localparam logic [BTN_IDX_BITS-1:0] BTN_LAST = BTN_IDX_BITS'(BUTTON_COUNT - 1);

	state_t state_q, state_d;

	logic [BTN_IDX_BITS-1:0] idx_q;
	logic [BUTTON_COUNT-1:0] level_q;
	logic [BUTTON_COUNT-1:0] handled_q;
	logic [TIME_BITS-1:0]    press_q   [BUTTON_COUNT];
	logic [TIME_BITS-1:0]    release_q [BUTTON_COUNT];

	logic [BUTTON_COUNT-1:0] cmask_q;
	logic [1:0]              cnt_q;
	logic [TIME_BITS-1:0]    lo_q, hi_q;
	logic [BTN_IDX_BITS-1:0] only_q;
	logic                    combo_long_q;

	logic [CFG_DATA_BITS-1:0] combo_window_q, long_press_q;

	logic                 out_valid_q;
	logic [KIND_BITS-1:0] out_kind_q;
	logic [MASK_BITS-1:0] out_mask_q;
	logic                 out_last_q;

	logic [BTN_IDX_BITS-1:0] evt_idx;
	logic                    id_ok, evt_fire;
	logic [TIME_BITS-1:0]    evt_time;
	logic                    last_idx, cur_cand, more_after, out_free;
	logic                    hold_back, step;
	logic                    out_load;
	logic [KIND_BITS-1:0]    out_kind_d;
	logic [MASK_BITS-1:0]    out_mask_d;
	logic                    out_last_d;
	logic [BUTTON_COUNT-1:0] handled_set;
	logic [TIME_BITS-1:0]    cw_ext, lp_ext;
	logic                    scan_cand;
	unit_req_t               unit_req;
	unit_rsp_t               unit_rsp;

	// Shared subtract-and-compare unit
	bgc_time_unit u_unit (
		.req (unit_req),
		.rsp (unit_rsp)
	);

	// Event decode
	assign evt_idx  = BTN_IDX_BITS'(btn_evt.btn_sel);
	assign id_ok    = 32'(btn_evt.btn_sel) < 32'(BUTTON_COUNT);
	assign evt_fire = btn_evt.valid && btn_evt.ready && id_ok;
	assign evt_time = btn_evt.timestamp[TIME_BITS-1:0];

	// Per-button views
	assign last_idx  = idx_q == BTN_LAST;
	assign cur_cand  = cmask_q[idx_q];
	assign scan_cand = !handled_q[idx_q] && level_q[idx_q];
	assign out_free  = !out_valid_q || gesture.ready;
	assign cw_ext    = TIME_BITS'(combo_window_q);
	assign lp_ext    = TIME_BITS'(long_press_q);

	// Flag candidates above the current button
	always_comb begin
		more_after = 1'b0;
		for (int j = 0; j < BUTTON_COUNT; j++) begin
			if (cmask_q[j] && (BTN_IDX_BITS'(j) > idx_q)) begin
				more_after = 1'b1;
			end
		end
	end

	// Shared unit operands: hold time by default, spread or distance on demand
	always_comb begin
		unit_req.a       = release_q[idx_q];
		unit_req.b       = press_q[idx_q];
		unit_req.thr     = lp_ext;
		unit_req.use_abs = 1'b0;
		case (state_q)
			S_DECIDE: begin
				unit_req.a   = hi_q;
				unit_req.b   = lo_q;
				unit_req.thr = cw_ext;
			end
			S_WAIT: begin
				unit_req.a       = press_q[only_q];
				unit_req.b       = press_q[idx_q];
				unit_req.thr     = cw_ext;
				unit_req.use_abs = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		btn_evt.ready = 1'b0;
		hold_back   = 1'b0;
		step        = 1'b0;
		out_load    = 1'b0;
		out_kind_d  = GK_CLICK;
		out_mask_d  = MASK_BITS'(BUTTON_COUNT'(1) << idx_q);
		out_last_d  = !more_after;
		handled_set = '0;
		case (state_q)
			S_IDLE: begin
				btn_evt.ready = 1'b1;
			end
			S_SCAN: begin
				step = 1'b1;
			end
			S_DECIDE: begin
				step = 1'b0;
			end
			S_CLONG: begin
				step = 1'b1;
			end
			S_PUT: begin
				out_load    = out_free;
				out_kind_d  = combo_long_q ? GK_LONG_COMBO : GK_COMBO;
				out_mask_d  = MASK_BITS'(cmask_q);
				out_last_d  = 1'b1;
				handled_set = out_free ? cmask_q : '0;
			end
			S_WAIT: begin
				hold_back = (idx_q != only_q) && !handled_q[idx_q] && !level_q[idx_q]
				            && unit_rsp.le;
				step      = !hold_back;
			end
			S_EMIT: begin
				step       = !cur_cand || out_free;
				out_load   = cur_cand && out_free;
				out_kind_d = unit_rsp.ge ? GK_LONG : GK_CLICK;
				if (cur_cand && out_free) begin
					handled_set[idx_q] = 1'b1;
				end
			end
			default: begin
				btn_evt.ready = 1'b0;
			end
		endcase
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (evt_fire) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (last_idx) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (cnt_q == 2'd0) begin
					state_d = S_IDLE;
				end else if (cnt_q == 2'd1) begin
					state_d = S_WAIT;
				end else if (unit_rsp.le) begin
					state_d = S_CLONG;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_CLONG: begin
				if (last_idx) state_d = S_PUT;
			end
			S_PUT: begin
				if (out_free) state_d = S_IDLE;
			end
			S_WAIT: begin
				if (hold_back) begin
					state_d = S_IDLE;
				end else if (last_idx) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (step && last_idx) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and button index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d == S_IDLE) begin
				idx_q <= '0;
			end else if (step) begin
				idx_q <= last_idx ? '0 : idx_q + 1'b1;
			end
		end
	end

	// Per-button state: record the event, mark reported buttons handled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '1;
			handled_q <= '1;
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				press_q[i]   <= '0;
				release_q[i] <= '0;
			end
		end else begin
			handled_q <= handled_q | handled_set;
			if (evt_fire) begin
				level_q[evt_idx] <= btn_evt.level;
				if (btn_evt.level) begin
					release_q[evt_idx] <= evt_time;
				end else begin
					press_q[evt_idx]   <= evt_time;
					handled_q[evt_idx] <= 1'b0;
				end
			end
		end
	end

	// Candidate scan: mask, count, lone candidate and combo long flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmask_q      <= '0;
			cnt_q        <= '0;
			only_q       <= '0;
			combo_long_q <= 1'b0;
		end else begin
			if (evt_fire) begin
				cmask_q <= '0;
				cnt_q   <= '0;
			end
			if (state_q == S_SCAN && scan_cand) begin
				cmask_q[idx_q] <= 1'b1;
				if (cnt_q != 2'd2) cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 2'd0) only_q <= idx_q;
			end
			if (state_q == S_DECIDE) begin
				combo_long_q <= 1'b1;
			end
			if (state_q == S_CLONG && cur_cand && !unit_rsp.ge) begin
				combo_long_q <= 1'b0;
			end
		end
	end

	// Press time range of the candidates
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && scan_cand) begin
			if (cnt_q == 2'd0 || press_q[idx_q] < lo_q) lo_q <= press_q[idx_q];
			if (cnt_q == 2'd0 || press_q[idx_q] > hi_q) hi_q <= press_q[idx_q];
		end
	end

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			combo_window_q <= COMBO_WINDOW_RST;
			long_press_q   <= LONG_PRESS_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				CFG_COMBO_WINDOW: combo_window_q <= cfg.data;
				CFG_LONG_PRESS:   long_press_q   <= cfg.data;
				default:          combo_window_q <= combo_window_q;
			endcase
		end
	end

	// Output register: hold a beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (gesture.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_mask_q <= out_mask_d;
			out_last_q <= out_last_d;
		end
	end

	assign gesture.valid        = out_valid_q;
	assign gesture.gesture_kind = out_kind_q;
	assign gesture.button_mask  = out_mask_q;
	assign gesture.last_result  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/bgc_checker.sv -----
// ----------------------------------------------------------------------------
// bgc_checker
// Port-level checks of the button gesture classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_checker import bgc_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               evt_valid,
	input wire logic               evt_ready,
	input wire logic [ID_BITS-1:0] evt_btn_sel,
	input wire logic               gst_valid,
	input wire logic               gst_ready,
	input wire logic               gst_last,
	input wire logic               cfg_valid,
	input wire logic               cfg_ready
);

	// A pending gesture beat stays until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		gst_valid && !gst_ready |=> gst_valid)
		else $error("gesture beat dropped before it was taken");

	// An event for a real button keeps the block busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && (32'(evt_btn_sel) < 32'(BUTTON_COUNT)) |=> !evt_ready)
		else $error("block ready straight after taking a button event");

	// An event for a missing button is dropped and the block stays ready
	assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && (32'(evt_btn_sel) >= 32'(BUTTON_COUNT)) |=> evt_ready)
		else $error("out-of-range event stalled the block");

	// More beats of the same event follow, so no new event may be taken
	assert property (@(posedge clk) disable iff (!arst_n)
		gst_valid && !gst_last |-> !evt_ready)
		else $error("new event taken while gesture beats are still pending");

	// Register writes are never stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.evt_valid   (btn_evt.valid),
	.evt_ready   (btn_evt.ready),
	.evt_btn_sel (btn_evt.btn_sel),
	.gst_valid   (gesture.valid),
	.gst_ready   (gesture.ready),
	.gst_last    (gesture.last_result),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready)
);

`default_nettype wire

// ----- verif/tb_button_gesture_classifier.sv -----
// ----------------------------------------------------------------------------
// tb_button_gesture_classifier
// Self-checking bench for the button gesture classifier. A behavioural
// predictor follows every accepted button edge and queues the gestures it
// should give. Directed cases cover clicks, long presses, combos, held-back
// lone releases, wide spreads, time wrap and repeated levels. Random press and
// release sequences then run under several register settings, with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_button_gesture_classifier;
	import bgc_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int DRAIN_CYCLES = 24;
	localparam int RUN_LIMIT    = 3_000_000;
	localparam int MAX_GAP      = 14;

	typedef struct packed {
		gesture_kind_t        kind;
		logic [MASK_BITS-1:0] mask;
		logic                 last;
	} gesture_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	bgc_event_if   evt_ch ();
	bgc_gesture_if gest_ch ();
	bgc_cfg_if     cfg_ch ();

	button_gesture_classifier dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.btn_evt (evt_ch),
		.gesture (gest_ch),
		.cfg     (cfg_ch)
	);

	// Predictor state: per-button level, handled flag and edge times
	logic                 btn_level     [BUTTON_COUNT];
	logic                 btn_handled   [BUTTON_COUNT];
	logic [TIME_BITS-1:0] btn_press_t   [BUTTON_COUNT];
	logic [TIME_BITS-1:0] btn_release_t [BUTTON_COUNT];
	logic [CFG_DATA_BITS-1:0] win_ticks;
	logic [CFG_DATA_BITS-1:0] long_ticks;

	gesture_rec_t gestures_due [$];

	int  mismatches;
	int  events_sent;
	int  gestures_seen;
	int  settings_run;
	bit  no_gaps;
	logic [TS_BITS-1:0] tick_now;

	// Clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Safety net against a hung handshake
	initial begin
		#RUN_LIMIT;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int pick_gap();
		return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic bit held_long(int b);
		logic [TIME_BITS-1:0] dur;
		dur = btn_release_t[b] - btn_press_t[b];
		return dur >= long_ticks;
	endfunction

	// Advance the predictor by one button edge and queue the gestures it gives
	function automatic void classify_edge(logic [ID_BITS-1:0] id, logic lvl,
			logic [TS_BITS-1:0] ts);
		logic [MASK_BITS-1:0] cand;
		logic [TIME_BITS-1:0] lo, hi, dt;
		gesture_rec_t         found [BUTTON_COUNT];
		int                   cnt, n, only;
		bit                   combo_long, hold;
		cand = '0;
		lo = '1;
		hi = '0;
		cnt = 0;
		n = 0;
		only = 0;
		combo_long = 1'b1;
		hold = 1'b0;
		if (id >= BUTTON_COUNT) return;

		btn_level[id] = lvl;
		if (lvl) begin
			btn_release_t[id] = ts[TIME_BITS-1:0];
		end else begin
			btn_press_t[id] = ts[TIME_BITS-1:0];
			btn_handled[id] = 1'b0;
		end

		// Gather released buttons not yet reported
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			if (!btn_handled[i] && btn_level[i]) begin
				cand[i] = 1'b1;
				cnt++;
				if (btn_press_t[i] < lo) lo = btn_press_t[i];
				if (btn_press_t[i] > hi) hi = btn_press_t[i];
			end
		end
		if (cnt == 0) return;

		if (cnt >= 2 && (hi - lo) <= win_ticks) begin
			// One combo for all candidates
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				if (cand[i]) begin
					if (!held_long(i)) combo_long = 1'b0;
					btn_handled[i] = 1'b1;
				end
			end
			found[0].kind = combo_long ? GK_LONG_COMBO : GK_COMBO;
			found[0].mask = cand;
			n = 1;
		end else if (cnt == 1) begin
			for (int i = BUTTON_COUNT - 1; i >= 0; i--)
				if (cand[i]) only = i;
			// Hold back while a close partner is still down
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				if (i != only && !btn_handled[i] && !btn_level[i]) begin
					dt = (btn_press_t[only] > btn_press_t[i]) ?
						btn_press_t[only] - btn_press_t[i] :
						btn_press_t[i] - btn_press_t[only];
					if (dt <= win_ticks) hold = 1'b1;
				end
			end
			if (hold) return;
			found[0].kind = held_long(only) ? GK_LONG : GK_CLICK;
			found[0].mask = MASK_BITS'(1 << only);
			btn_handled[only] = 1'b1;
			n = 1;
		end else begin
			// Spread too wide: one gesture per button, lowest first
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				if (cand[i]) begin
					found[n].kind = held_long(i) ? GK_LONG : GK_CLICK;
					found[n].mask = MASK_BITS'(1 << i);
					btn_handled[i] = 1'b1;
					n++;
				end
			end
		end

		for (int k = 0; k < n; k++) begin
			found[k].last = (k == n - 1);
			gestures_due.push_back(found[k]);
		end
	endfunction

	task automatic flag_mismatch(string what, gesture_rec_t want,
			logic [KIND_BITS-1:0] k, logic [MASK_BITS-1:0] m, logic l);
		if (mismatches < 10)
			$display("mismatch (%s) at %0t: expected kind %0d mask %b last %b,",
				what, $time, want.kind, want.mask, want.last,
				" got kind %0d mask %b last %b", k, m, l);
		mismatches++;
	endtask

	// Check each gesture beat against the oldest expectation
	always @(posedge clk) begin
		gesture_rec_t want;
		if (arst_n && gest_ch.valid && gest_ch.ready) begin
			gestures_seen++;
			if (gestures_due.size() == 0) begin
				want = '0;
				flag_mismatch("beat with nothing expected", want, gest_ch.gesture_kind,
					gest_ch.button_mask, gest_ch.last_result);
			end else begin
				want = gestures_due.pop_front();
				if (gest_ch.gesture_kind !== want.kind)
					flag_mismatch("gesture_kind", want, gest_ch.gesture_kind,
						gest_ch.button_mask, gest_ch.last_result);
				else if (gest_ch.button_mask !== want.mask)
					flag_mismatch("button_mask", want, gest_ch.gesture_kind,
						gest_ch.button_mask, gest_ch.last_result);
				else if (gest_ch.last_result !== want.last)
					flag_mismatch("last_result", want, gest_ch.gesture_kind,
						gest_ch.button_mask, gest_ch.last_result);
			end
		end
	end

	// Gesture sink: stall a random number of cycles before each beat
	initial begin
		int stall;
		gest_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = pick_gap();
			repeat (stall) begin
				@(negedge clk);
				gest_ch.ready <= 1'b0;
			end
			@(negedge clk);
			gest_ch.ready <= 1'b1;
			do @(posedge clk); while (!(gest_ch.valid && gest_ch.ready));
		end
	end

	// Send one button edge; valid stays up when the next beat follows at once
	task automatic send_event(logic [ID_BITS-1:0] id, logic lvl, logic [TS_BITS-1:0] ts);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			evt_ch.valid <= 1'b0;
		end
		@(negedge clk);
		evt_ch.valid     <= 1'b1;
		evt_ch.btn_sel   <= id;
		evt_ch.level     <= lvl;
		evt_ch.timestamp <= ts;
		do @(posedge clk); while (!evt_ch.ready);
		classify_edge(id, lvl, ts);
		if (id < BUTTON_COUNT) events_sent++;
	endtask

	// Drop valid, drain expected gestures, then let the sequencer go quiet
	task automatic settle();
		@(negedge clk);
		evt_ch.valid <= 1'b0;
		while (gestures_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
		settle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_COMBO_WINDOW: win_ticks = val;
			CFG_LONG_PRESS:   long_ticks = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Press a random set of buttons close together, release in random order
	task automatic play_gesture();
		int order [BUTTON_COUNT];
		int n, j, t, w, l;
		w = int'(win_ticks);
		l = int'(long_ticks);
		for (int k = 0; k < BUTTON_COUNT; k++) order[k] = k;
		for (int k = BUTTON_COUNT - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = order[k]; order[k] = order[j]; order[j] = t;
		end
		n = $urandom_range(1, BUTTON_COUNT);
		tick_now += $urandom_range(1, 2000);
		for (int k = 0; k < n; k++) begin
			if (k > 0) tick_now += $urandom_range(0, w + w / 2 + 1);
			send_event(ID_BITS'(order[k]), 1'b0, tick_now);
		end
		for (int k = n - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = order[k]; order[k] = order[j]; order[j] = t;
		end
		for (int k = 0; k < n; k++) begin
			if (k == 0) tick_now += $urandom_range(0, l + l / 4 + 1);
			else tick_now += $urandom_range(0, w + 1);
			send_event(ID_BITS'(order[k]), 1'b1, tick_now);
		end
	endtask

	task automatic run_random(int count);
		int target, pick;
		target = events_sent + count;
		settings_run++;
		while (events_sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick % 4 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			if (pick < 2) begin
				send_event(ID_BITS'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					$urandom());
			end else if (pick == 2) begin
				tick_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
				play_gesture();
			end else begin
				play_gesture();
			end
		end
		settle();
	endtask

	// Out-of-range button index: taken and dropped
	task automatic test_ignored_button();
		send_event(ID_BITS'(3), 1'b0, 32'd50);
		send_event(ID_BITS'(3), 1'b1, 32'hFFFF_FFFF);
	endtask

	// Lone click, long press at and just below the threshold
	task automatic test_single_presses();
		send_event(2'd0, 1'b0, 32'd0);
		send_event(2'd0, 1'b1, 32'd300);
		send_event(2'd1, 1'b0, 32'd1000);
		send_event(2'd1, 1'b1, 32'd1750);
		send_event(2'd1, 1'b0, 32'd2000);
		send_event(2'd1, 1'b1, 32'd2749);
	endtask

	// Two-button combos, long and short; first release is held back
	task automatic test_combos();
		send_event(2'd0, 1'b0, 32'd5000);
		send_event(2'd1, 1'b0, 32'd5100);
		send_event(2'd0, 1'b1, 32'd6000);
		send_event(2'd1, 1'b1, 32'd6100);
		send_event(2'd0, 1'b0, 32'd7000);
		send_event(2'd1, 1'b0, 32'd7050);
		send_event(2'd1, 1'b1, 32'd7100);
		send_event(2'd0, 1'b1, 32'd7900);
	endtask

	// Candidates too far apart: separate gestures in button order
	task automatic test_wide_spread();
		send_event(2'd0, 1'b0, 32'd10000);
		send_event(2'd1, 1'b0, 32'd10150);
		send_event(2'd2, 1'b0, 32'd10300);
		send_event(2'd0, 1'b1, 32'd10400);
		send_event(2'd2, 1'b1, 32'd10500);
		send_event(2'd1, 1'b1, 32'd10600);
	endtask

	// Hold duration wraps through the top of the tick counter
	task automatic test_time_wrap();
		send_event(2'd2, 1'b0, 32'hFFFF_FFFF);
		send_event(2'd2, 1'b1, 32'h0000_0400);
	endtask

	// Repeated press re-times; repeated release of a handled button is silent
	task automatic test_repeated_level();
		send_event(2'd0, 1'b0, 32'd20000);
		send_event(2'd0, 1'b0, 32'd21000);
		send_event(2'd0, 1'b1, 32'd21100);
		send_event(2'd0, 1'b1, 32'd22000);
	endtask

	// Random sequences under reset, extreme and random register values
	task automatic test_register_sweep();
		no_gaps = 1'b0;
		run_random(80);
		write_reg(CFG_COMBO_WINDOW, 16'd0);
		write_reg(CFG_LONG_PRESS, 16'd1);
		run_random(80);
		write_reg(CFG_COMBO_WINDOW, 16'hFFFF);
		write_reg(CFG_LONG_PRESS, 16'hFFFF);
		run_random(80);
		write_reg(CFG_COMBO_WINDOW, 16'($urandom_range(1, 1000)));
		write_reg(CFG_LONG_PRESS, 16'($urandom_range(1, 3000)));
		run_random(80);
		write_reg(CFG_COMBO_WINDOW, COMBO_WINDOW_RST);
		write_reg(CFG_LONG_PRESS, LONG_PRESS_RST);
		run_random(80);
	endtask

	initial begin
		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.btn_sel = '0;
		evt_ch.level = 1'b1;
		evt_ch.timestamp = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_COMBO_WINDOW;
		cfg_ch.data = '0;
		mismatches = 0;
		events_sent = 0;
		gestures_seen = 0;
		settings_run = 0;
		no_gaps = 1'b0;
		tick_now = 32'd30000;
		win_ticks = COMBO_WINDOW_RST;
		long_ticks = LONG_PRESS_RST;
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			btn_level[i] = 1'b1;
			btn_handled[i] = 1'b1;
			btn_press_t[i] = '0;
			btn_release_t[i] = '0;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_ignored_button();
		test_single_presses();
		no_gaps = 1'b1;
		test_combos();
		no_gaps = 1'b0;
		test_wide_spread();
		test_time_wrap();
		test_repeated_level();
		settle();
		test_register_sweep();
		settle();

		$display("covered %0d button edges, %0d gestures checked, %0d register settings",
			events_sent, gestures_seen, settings_run);
		if (mismatches == 0 && gestures_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d gestures still expected", mismatches,
				gestures_due.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
